// File: rtl/tiled_texture_store_fetch_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the tiled texture store
// Implication checks, same cycle and next cycle; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef TILED_TEXTURE_STORE_FETCH_MACROS_SVH
`define TILED_TEXTURE_STORE_FETCH_MACROS_SVH

`ifndef SYNTHESIS

`define TTSF_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`define TTSF_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define TTSF_ASSERT_IMP(label, clk, rst, ante, cons)

`define TTSF_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

// File: rtl/ttsf_pkg.sv
// ----------------------------------------------------------------------------
// ttsf_pkg
// Shared constants, codes and types of the tiled texture store.
// ----------------------------------------------------------------------------
package ttsf_pkg;

  localparam int TEX_MAX_DIM  = 256;
  localparam int TEX_MAX_LOG2 = $clog2(TEX_MAX_DIM);
  localparam int TEX_MIN_LOG2 = 6;
  localparam int TILE_LOG2    = 3;
  localparam int STORE_DEPTH  = TEX_MAX_DIM * TEX_MAX_DIM;
  localparam int ADDR_W       = $clog2(STORE_DEPTH);

  localparam int COLOR_W = 32;
  localparam int PIX_W   = 11;
  localparam int CRD_W   = 13;
  // tile index bits + morton bits, wide enough for any non-negative coordinate
  localparam int LIN_W   = (CRD_W - 1 - TILE_LOG2) + (TEX_MAX_LOG2 - TILE_LOG2) + 1
                           + 2 * TILE_LOG2;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [1:0] {
    CMD_WRITE     = 2'd0,
    CMD_READ_RAW  = 2'd1,
    CMD_READ_TINT = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEX_WIDTH_LOG2  = 3'd0,
    REG_TEX_HEIGHT_LOG2 = 3'd1,
    REG_IMAGE_WIDTH     = 3'd2,
    REG_IMAGE_HEIGHT    = 3'd3,
    REG_ORIGIN_X        = 3'd4,
    REG_ORIGIN_Y        = 3'd5,
    REG_ROTATED         = 3'd6,
    REG_TINT            = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [3:0]         tex_width_log2;
    logic [3:0]         tex_height_log2;
    logic [8:0]         image_width;
    logic [8:0]         image_height;
    logic [7:0]         origin_x;
    logic [7:0]         origin_y;
    logic               rotated;
    logic [COLOR_W-1:0] tint;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    tex_width_log2:  4'd8,
    tex_height_log2: 4'd8,
    image_width:     9'd256,
    image_height:    9'd256,
    origin_x:        8'd0,
    origin_y:        8'd0,
    rotated:         1'b0,
    tint:            32'hFFFF_FFFF
  };

  typedef struct packed {
    logic               is_write;
    logic               tinted;
    logic               oos;
    logic [ADDR_W-1:0]  addr;
    logic [COLOR_W-1:0] color;
  } q_entry_t;

endpackage

// File: rtl/ttsf_req_if.sv
// ----------------------------------------------------------------------------
// ttsf_req_if
// Request channel: command, sprite coordinates and colour.
// ----------------------------------------------------------------------------
interface ttsf_req_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       cmd;
  logic signed [ttsf_pkg::PIX_W-1:0] pixel_x;
  logic signed [ttsf_pkg::PIX_W-1:0] pixel_y;
  logic [ttsf_pkg::COLOR_W-1:0]     pixel_color;

  modport source (output valid, cmd, pixel_x, pixel_y, pixel_color, input ready);
  modport sink   (input valid, cmd, pixel_x, pixel_y, pixel_color, output ready);
endinterface

// File: rtl/ttsf_rsp_if.sv
// ----------------------------------------------------------------------------
// ttsf_rsp_if
// Result channel: fetched colour and flags.
// ----------------------------------------------------------------------------
interface ttsf_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [ttsf_pkg::COLOR_W-1:0] read_color;
  logic                         transparent;
  logic                         out_of_store;

  modport source (output valid, read_color, transparent, out_of_store, input ready);
  modport sink   (input valid, read_color, transparent, out_of_store, output ready);
endinterface

// File: rtl/ttsf_queue.sv
// ----------------------------------------------------------------------------
// ttsf_queue
// Short FIFO of classified operations between front and back.
// ----------------------------------------------------------------------------
module ttsf_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  ttsf_pkg::q_entry_t push_entry,
  output logic               full,
  output logic               valid,
  output ttsf_pkg::q_entry_t entry,
  input  logic               pop
);

  ttsf_pkg::q_entry_t                 slots [ttsf_pkg::Q_DEPTH];
  logic [ttsf_pkg::Q_PTR_W-1:0] wr_ptr;
  logic [ttsf_pkg::Q_PTR_W-1:0] rd_ptr;
  logic [ttsf_pkg::Q_CNT_W-1:0] count;

  assign full  = (count == ttsf_pkg::Q_CNT_W'(ttsf_pkg::Q_DEPTH));
  assign valid = (count != '0);
  assign entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/ttsf_front.sv
// ----------------------------------------------------------------------------
// ttsf_front
// Takes requests, maps coordinates, swizzles the address and classifies.
// ----------------------------------------------------------------------------
module ttsf_front (
  ttsf_req_if.sink           req,
  input  ttsf_pkg::cfg_t     cfg,
  input  logic               q_full,
  input  logic               clearing,
  output logic               push,
  output ttsf_pkg::q_entry_t push_entry
);

  localparam int CW   = ttsf_pkg::CRD_W;
  localparam int TL   = ttsf_pkg::TILE_LOG2;
  localparam int LW   = ttsf_pkg::LIN_W;
  localparam int TI_W = LW - 2 * TL;

  function automatic logic [3:0] eff_log2(input logic [3:0] lg);
    if (lg < 4'(ttsf_pkg::TEX_MIN_LOG2)) begin
      return 4'(ttsf_pkg::TEX_MIN_LOG2);
    end else if (lg > 4'(ttsf_pkg::TEX_MAX_LOG2)) begin
      return 4'(ttsf_pkg::TEX_MAX_LOG2);
    end
    return lg;
  endfunction

  logic [3:0]           lw, lh;
  logic signed [CW-1:0] x_s, y_s, ox_s, oy_s, iw_s;
  logic signed [CW-1:0] sx, sy, cx, cy;
  logic [CW-2:0]        ux, uy;
  logic [2*TL-1:0]      morton;
  logic [TI_W-1:0]      tile_idx;
  logic [LW-1:0]        lin;
  logic                 is_write, in_image, coord_ok, in_store;

  assign req.ready = !q_full && !clearing;

  always_comb begin
    lw   = eff_log2(cfg.tex_width_log2);
    lh   = eff_log2(cfg.tex_height_log2);
    x_s  = CW'(req.pixel_x);
    y_s  = CW'(req.pixel_y);
    ox_s = CW'({1'b0, cfg.origin_x});
    oy_s = CW'({1'b0, cfg.origin_y});
    iw_s = CW'({1'b0, cfg.image_width});

    // rotated: sy = oy + w - 1 - x, with -1 - x folded into ~x
    if (cfg.rotated) begin
      sx = y_s + ox_s;
      sy = oy_s + iw_s + ~x_s;
    end else begin
      sx = x_s + ox_s;
      sy = y_s + oy_s;
    end

    is_write = (req.cmd == ttsf_pkg::CMD_WRITE);
    in_image = !req.pixel_x[ttsf_pkg::PIX_W-1] && !req.pixel_y[ttsf_pkg::PIX_W-1] &&
               ({1'b0, req.pixel_x[ttsf_pkg::PIX_W-2:0]} < {2'b00, cfg.image_width}) &&
               ({1'b0, req.pixel_y[ttsf_pkg::PIX_W-2:0]} < {2'b00, cfg.image_height});

    cx = is_write ? x_s : sx;
    cy = is_write ? y_s : sy;
    coord_ok = !cx[CW-1] && !cy[CW-1];
    ux = cx[CW-2:0];
    uy = cy[CW-2:0];

    for (int i = 0; i < TL; i++) begin
      morton[2*i]   = ux[i];
      morton[2*i+1] = uy[i];
    end
    tile_idx = (TI_W'(uy[CW-2:TL]) << (lw - 4'(TL))) + TI_W'(ux[CW-2:TL]);
    lin      = {tile_idx, morton};
    in_store = ((lin >> ({1'b0, lw} + {1'b0, lh})) == '0);

    push_entry.is_write = is_write;
    push_entry.tinted   = (req.cmd == ttsf_pkg::CMD_READ_TINT);
    push_entry.oos      = !(coord_ok && in_store);
    push_entry.addr     = lin[ttsf_pkg::ADDR_W-1:0];
    push_entry.color    = req.pixel_color;

    push = 1'b0;
    if (req.valid && req.ready) begin
      unique case (req.cmd) inside
        ttsf_pkg::CMD_WRITE: begin
          push = in_image && coord_ok && in_store;
        end
        ttsf_pkg::CMD_READ_RAW, ttsf_pkg::CMD_READ_TINT: begin
          push = 1'b1;
        end
        default: begin
          push = 1'b0;
        end
      endcase
    end
  end

endmodule

// File: rtl/ttsf_back.sv
// ----------------------------------------------------------------------------
// ttsf_back
// Texel store, clear sweep after reset, fetch, tint and result register.
// ----------------------------------------------------------------------------
module ttsf_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  input  ttsf_pkg::q_entry_t           q_entry,
  output logic                         pop,
  output logic                         clearing,
  input  logic [ttsf_pkg::COLOR_W-1:0] tint,
  ttsf_rsp_if.source                   rsp
);

  localparam int AW = ttsf_pkg::ADDR_W;
  localparam int CL = ttsf_pkg::COLOR_W;

  // c * t / 255 per byte; exact for products up to 255 * 255
  function automatic logic [CL-1:0] tint_color(input logic [CL-1:0] c,
                                               input logic [CL-1:0] t);
    logic [CL-1:0] res;
    logic [15:0]   p;
    logic [16:0]   q;
    res = '0;
    for (int b = 0; b < CL / 8; b++) begin
      p = c[8*b +: 8] * t[8*b +: 8];
      q = {1'b0, p} + 17'(p >> 8) + 17'd1;
      res[8*b +: 8] = q[15:8];
    end
    return res;
  endfunction

  logic [CL-1:0] store [ttsf_pkg::STORE_DEPTH];
  logic [AW:0]   clr_cnt;
  logic          mem_we, rd_en;
  logic [AW-1:0] mem_waddr;
  logic [CL-1:0] mem_wdata, rdata;
  logic          s1_valid, s1_tinted, s1_oos, s1_go;
  logic [CL-1:0] s1_color;
  logic          out_valid, out_transp, out_oos;
  logic [CL-1:0] out_color;

  assign clearing  = !clr_cnt[AW];
  assign s1_go     = s1_valid && (!out_valid || rsp.ready);
  assign pop       = q_valid && !clearing && (!s1_valid || s1_go);
  assign rd_en     = pop && !q_entry.is_write && !q_entry.oos;
  assign mem_we    = clearing || (pop && q_entry.is_write);
  assign mem_waddr = clearing ? clr_cnt[AW-1:0] : q_entry.addr;
  assign mem_wdata = clearing ? '0 : q_entry.color;

  always_comb begin
    if (s1_oos) begin
      s1_color = '0;
    end else if (s1_tinted) begin
      s1_color = tint_color(rdata, tint);
    end else begin
      s1_color = rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rdata <= store[q_entry.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop && !q_entry.is_write) begin
        s1_valid <= 1'b1;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end
      if (s1_go) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && !q_entry.is_write) begin
      s1_tinted <= q_entry.tinted;
      s1_oos    <= q_entry.oos;
    end
    if (s1_go) begin
      out_color  <= s1_color;
      out_transp <= (s1_color[7:0] == 8'd0);
      out_oos    <= s1_oos;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.read_color   = out_color;
  assign rsp.transparent  = out_transp;
  assign rsp.out_of_store = out_oos;

endmodule

// File: rtl/tiled_texture_store_fetch.sv
// ----------------------------------------------------------------------------
// tiled_texture_store_fetch
// Tiled (8x8, Morton) RGBA texel store with pixel write and texel fetch.
// Throughput: one request per cycle, set by the single store port, unless
// the queue is full or the sweep runs. A taken read passes the queue, the
// store read register and the result register. Reset: registers take their
// defaults; a sweep then zeroes the store, one texel a cycle, req.ready low.
// ----------------------------------------------------------------------------
module tiled_texture_store_fetch (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [ttsf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ttsf_pkg::CFG_DATA_W-1:0] cfg_data,
  ttsf_req_if.sink                        req,
  ttsf_rsp_if.source                      rsp
);

  `include "tiled_texture_store_fetch_macros.svh"

  ttsf_pkg::cfg_t     cfg;
  ttsf_pkg::q_entry_t push_entry, q_entry;
  logic               push, q_full, q_valid, pop, clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= ttsf_pkg::CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ttsf_pkg::REG_TEX_WIDTH_LOG2:  cfg.tex_width_log2  <= cfg_data[3:0];
        ttsf_pkg::REG_TEX_HEIGHT_LOG2: cfg.tex_height_log2 <= cfg_data[3:0];
        ttsf_pkg::REG_IMAGE_WIDTH:     cfg.image_width     <= cfg_data[8:0];
        ttsf_pkg::REG_IMAGE_HEIGHT:    cfg.image_height    <= cfg_data[8:0];
        ttsf_pkg::REG_ORIGIN_X:        cfg.origin_x        <= cfg_data[7:0];
        ttsf_pkg::REG_ORIGIN_Y:        cfg.origin_y        <= cfg_data[7:0];
        ttsf_pkg::REG_ROTATED:         cfg.rotated         <= cfg_data[0];
        ttsf_pkg::REG_TINT:            cfg.tint            <= cfg_data[31:0];
        default:                       cfg                 <= cfg;
      endcase
    end
  end

  ttsf_front u_front (
    .req        (req),
    .cfg        (cfg),
    .q_full     (q_full),
    .clearing   (clearing),
    .push       (push),
    .push_entry (push_entry)
  );

  ttsf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .valid      (q_valid),
    .entry      (q_entry),
    .pop        (pop)
  );

  ttsf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_entry  (q_entry),
    .pop      (pop),
    .clearing (clearing),
    .tint     (cfg.tint),
    .rsp      (rsp)
  );

  `TTSF_ASSERT_IMP(a_no_req_while_clearing, clk, rst, clearing, !req.ready)
  `TTSF_ASSERT_IMP(a_no_rsp_while_clearing, clk, rst, clearing, !rsp.valid)
  `TTSF_ASSERT_IMP(a_oos_gives_zero, clk, rst, rsp.valid && rsp.out_of_store, rsp.read_color == '0 && rsp.transparent)
  `TTSF_ASSERT_NXT(a_read_queued, clk, rst, req.valid && req.ready && (req.cmd == ttsf_pkg::CMD_READ_RAW || req.cmd == ttsf_pkg::CMD_READ_TINT), q_valid)

endmodule
